// ----- rtl/sleep_timer_list_unit_defines.svh -----
// ----------------------------------------------------------------------------
// sleep_timer_list_unit_defines
// Assertion macros shared by the sleep timer list block.
// ----------------------------------------------------------------------------
`ifndef SLEEP_TIMER_LIST_UNIT_DEFINES_SVH
`define SLEEP_TIMER_LIST_UNIT_DEFINES_SVH

// check a same-cycle implication
`define STL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// check an implication in the next cycle
`define STL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// Types and codes of the sleep timer list block.
// ----------------------------------------------------------------------------
package stl_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PUSH   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_PUSHED   = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_REMOVED  = 3'd2,
        KIND_NOTFOUND = 3'd3,
        KIND_WOKEN    = 3'd4,
        KIND_NONE     = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] remaining;
    } entry_t;

    localparam int WOKE_W = 6;
    localparam logic [WOKE_W-1:0] MAX_RESULTS = 6'd32;

endpackage

// ----- rtl/stl_entry_ram.sv -----
// ----------------------------------------------------------------------------
// stl_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stl_entry_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  stl_pkg::entry_t     wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output stl_pkg::entry_t     rdata
);

    stl_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/sleep_timer_list_unit.sv -----
// ----------------------------------------------------------------------------
// sleep_timer_list_unit
// Ordered list of sleeping tasks with tick, push and remove operations.
// Push: the result word is registered from the FINISH state once the output is free.
// Tick and remove: one pass over the list through the entry RAM read port, then the
// final word from the FINISH state, held back while out_stall holds.
// One word is worked on at a time: the next command is taken only once the final
// result word is registered and the unit is back in its idle state.
// Reset clears the count, state, scan pointers and valid flags; entry RAM is not cleared.
// ----------------------------------------------------------------------------
`include "sleep_timer_list_unit_defines.svh"

module sleep_timer_list_unit #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  task_id,
    input  logic [15:0] delay,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  woken_task,
    output logic [6:0]  list_size,
    output logic        last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = stl_pkg::WOKE_W;

    stl_pkg::state_t              state_reg, state_next;
    stl_pkg::opcode_t             op_reg, op_next;
    logic [7:0]                   key_reg, key_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                scan_n_reg, scan_n_next;
    logic [CW-1:0]                r_reg, r_next;
    logic [CW-1:0]                w_reg, w_next;
    logic                         proc_valid_reg, proc_valid_next;
    logic                         found_reg, found_next;
    logic [stl_pkg::WOKE_W-1:0]   woke_cnt_reg, woke_cnt_next;
    logic                         pend_valid_reg, pend_valid_next;
    stl_pkg::kind_t               pend_kind_reg, pend_kind_next;
    logic [7:0]                   pend_task_reg, pend_task_next;
    logic                         out_valid_reg, out_valid_next;
    stl_pkg::kind_t               out_kind_reg, out_kind_next;
    logic [7:0]                   out_task_reg, out_task_next;
    logic [CW-1:0]                out_size_reg, out_size_next;
    logic                         out_last_reg, out_last_next;

    logic                         we;
    logic [AW-1:0]                waddr;
    stl_pkg::entry_t              wdata;
    logic                         re;
    stl_pkg::entry_t              rdata;

    logic                         out_free;
    logic [15:0]                  dec;
    logic                         proc_woke;
    logic                         proc_drop;
    logic                         proc_fire;
    logic                         in_take;

    stl_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (r_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign in_stall   = (state_reg != stl_pkg::ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign woken_task = out_task_reg;
    assign list_size  = 7'(out_size_reg);
    assign last       = out_last_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign dec       = (rdata.remaining == 16'd0) ? 16'd0 : rdata.remaining - 16'd1;
    assign proc_woke = (op_reg == stl_pkg::OP_TICK) && (dec == 16'd0)
                       && (woke_cnt_reg < stl_pkg::MAX_RESULTS);
    assign proc_drop = (op_reg == stl_pkg::OP_REMOVE) && !found_reg
                       && (rdata.task_id == key_reg);
    assign proc_fire = proc_valid_reg && !(proc_woke && pend_valid_reg && !out_free);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        cnt_next        = cnt_reg;
        scan_n_next     = scan_n_reg;
        r_next          = r_reg;
        w_next          = w_reg;
        proc_valid_next = proc_valid_reg;
        found_next      = found_reg;
        woke_cnt_next   = woke_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_task_next  = pend_task_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_task_next   = out_task_reg;
        out_size_next   = out_size_reg;
        out_last_next   = out_last_reg;
        we              = 1'b0;
        waddr           = w_reg[AW-1:0];
        wdata           = '{task_id: rdata.task_id,
                            remaining: (op_reg == stl_pkg::OP_TICK) ? dec : rdata.remaining};
        re              = 1'b0;

        unique case (state_reg)
            stl_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    op_next         = stl_pkg::opcode_t'(opcode);
                    key_next        = task_id;
                    scan_n_next     = cnt_reg;
                    r_next          = '0;
                    w_next          = '0;
                    found_next      = 1'b0;
                    woke_cnt_next   = '0;
                    pend_valid_next = 1'b0;
                    pend_task_next  = task_id;
                    unique case (stl_pkg::opcode_t'(opcode))
                        stl_pkg::OP_PUSH:
                        begin
                            pend_valid_next = 1'b1;
                            if (cnt_reg < CW'(CAPACITY))
                            begin
                                we             = 1'b1;
                                waddr          = cnt_reg[AW-1:0];
                                wdata          = '{task_id: task_id, remaining: delay};
                                cnt_next       = cnt_reg + CW'(1);
                                pend_kind_next = stl_pkg::KIND_PUSHED;
                            end
                            else
                            begin
                                pend_kind_next = stl_pkg::KIND_FULL;
                            end
                            state_next = stl_pkg::ST_FINISH;
                        end
                        stl_pkg::OP_REMOVE:
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = stl_pkg::KIND_NOTFOUND;
                            state_next      = stl_pkg::ST_SCAN;
                        end
                        stl_pkg::OP_TICK:
                        begin
                            state_next = stl_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            state_next = stl_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            stl_pkg::ST_SCAN:
            begin
                if (proc_fire)
                begin
                    proc_valid_next = 1'b0;
                    if (proc_woke)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = pend_kind_reg;
                            out_task_next  = pend_task_reg;
                            out_size_next  = cnt_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = stl_pkg::KIND_WOKEN;
                        pend_task_next  = rdata.task_id;
                        cnt_next        = cnt_reg - CW'(1);
                        woke_cnt_next   = woke_cnt_reg + WW'(1);
                    end
                    else if (proc_drop)
                    begin
                        found_next     = 1'b1;
                        pend_kind_next = stl_pkg::KIND_REMOVED;
                        cnt_next       = cnt_reg - CW'(1);
                    end
                    else
                    begin
                        we     = 1'b1;
                        w_next = w_reg + CW'(1);
                    end
                end
                if ((r_reg != scan_n_reg) && (!proc_valid_reg || proc_fire))
                begin
                    re              = 1'b1;
                    r_next          = r_reg + CW'(1);
                    proc_valid_next = 1'b1;
                end
                else if ((r_reg == scan_n_reg) && !proc_valid_next)
                begin
                    state_next = stl_pkg::ST_FINISH;
                end
            end
            stl_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_size_next  = cnt_reg;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next = pend_kind_reg;
                        out_task_next = pend_task_reg;
                    end
                    else
                    begin
                        out_kind_next = stl_pkg::KIND_NONE;
                        out_task_next = 8'd0;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = stl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stl_pkg::ST_IDLE;
            cnt_reg        <= '0;
            r_reg          <= '0;
            w_reg          <= '0;
            proc_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            woke_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            r_reg          <= r_next;
            w_reg          <= w_next;
            proc_valid_reg <= proc_valid_next;
            found_reg      <= found_next;
            woke_cnt_reg   <= woke_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        scan_n_reg    <= scan_n_next;
        pend_kind_reg <= pend_kind_next;
        pend_task_reg <= pend_task_next;
        out_kind_reg  <= out_kind_next;
        out_task_reg  <= out_task_next;
        out_size_reg  <= out_size_next;
        out_last_reg  <= out_last_next;
    end

    `STL_ASSERT_NOW(a_count_bound, 1'b1, cnt_reg <= CW'(CAPACITY))
    `STL_ASSERT_NOW(a_write_behind_read, state_reg == stl_pkg::ST_SCAN, w_reg <= r_reg)
    `STL_ASSERT_NOW(a_proc_in_scan, proc_valid_reg, state_reg == stl_pkg::ST_SCAN)
    `STL_ASSERT_NEXT(a_accept_busy, in_take && (opcode != stl_pkg::OP_NONE), in_stall)

endmodule

// ----- tb/sleep_timer_list_checker.sv -----
// ----------------------------------------------------------------------------
// sleep_timer_list_checker
// Watches the command and result channels of the sleep timer list block.
// Keeps its own copy of the task list and predicts the result words of every
// accepted command, then compares each accepted result word, field by field,
// against the oldest prediction. Hands a failure count and the number of
// predicted words still due to the testbench top.
// ----------------------------------------------------------------------------
module sleep_timer_list_checker #(
    parameter int CAPACITY = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  task_id,
    input  logic [15:0] delay,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [7:0]  woken_task,
    input  logic [6:0]  list_size,
    input  logic        last,
    output int          errors,
    output int          outstanding
);

    localparam int WAKE_LIMIT = int'(stl_pkg::MAX_RESULTS);

    typedef struct packed {
        stl_pkg::kind_t kind;
        logic [7:0]     task_id;
        logic [6:0]     size;
        logic           last;
    } result_word_t;

    result_word_t due_words[$];
    result_word_t oldest;

    logic [7:0]  slot_task  [CAPACITY];
    logic [15:0] slot_ticks [CAPACITY];
    int          slot_count;

    int fail_count = 0;
    int due_count  = 0;

    assign errors      = fail_count;
    assign outstanding = due_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] sleep list check: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    function automatic void drop_slot(input int pos);
        int i;
        for (i = pos; i + 1 < slot_count; i++)
        begin
            slot_task[i]  = slot_task[i + 1];
            slot_ticks[i] = slot_ticks[i + 1];
        end
        if (slot_count > 0)
            slot_count--;
    endfunction

    function automatic void predict_sleep_list(input stl_pkg::opcode_t op,
                                               input logic [7:0] tid,
                                               input logic [15:0] dly);
        result_word_t batch[$];
        logic [7:0]   woke;
        bit           found;
        int           i;
        found = 1'b0;
        case (op)
            stl_pkg::OP_PUSH:
            begin
                if (slot_count >= CAPACITY)
                begin
                    batch.push_back('{stl_pkg::KIND_FULL, tid, 7'(slot_count), 1'b0});
                end
                else
                begin
                    slot_task[slot_count]  = tid;
                    slot_ticks[slot_count] = dly;
                    slot_count++;
                    batch.push_back('{stl_pkg::KIND_PUSHED, tid, 7'(slot_count), 1'b0});
                end
            end
            stl_pkg::OP_REMOVE:
            begin
                for (i = 0; i < slot_count && !found; i++)
                begin
                    if (slot_task[i] == tid)
                    begin
                        drop_slot(i);
                        found = 1'b1;
                    end
                end
                batch.push_back('{found ? stl_pkg::KIND_REMOVED : stl_pkg::KIND_NOTFOUND,
                                  tid, 7'(slot_count), 1'b0});
            end
            stl_pkg::OP_TICK:
            begin
                for (i = 0; i < slot_count; i++)
                begin
                    if (slot_ticks[i] != 16'd0)
                        slot_ticks[i] = slot_ticks[i] - 16'd1;
                end
                i = 0;
                while (i < slot_count && batch.size() < WAKE_LIMIT)
                begin
                    if (slot_ticks[i] == 16'd0)
                    begin
                        woke = slot_task[i];
                        drop_slot(i);
                        batch.push_back('{stl_pkg::KIND_WOKEN, woke, 7'(slot_count), 1'b0});
                    end
                    else
                    begin
                        i++;
                    end
                end
                if (batch.size() == 0)
                    batch.push_back('{stl_pkg::KIND_NONE, 8'd0, 7'(slot_count), 1'b0});
            end
            default: ;
        endcase
        if (batch.size() > 0)
        begin
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[j])
                due_words.push_back(batch[j]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count = 0;
            due_words.delete();
            due_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_sleep_list(stl_pkg::opcode_t'(opcode), task_id, delay);
            if (out_valid && !out_stall)
            begin
                if (due_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word kind %0d task %0d size %0d last %0b",
                                              kind, woken_task, list_size, last));
                end
                else
                begin
                    oldest = due_words.pop_front();
                    if (kind !== oldest.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d", kind, oldest.kind));
                    if (woken_task !== oldest.task_id)
                        report_mismatch($sformatf("woken_task %0d, expected %0d",
                                                  woken_task, oldest.task_id));
                    if (list_size !== oldest.size)
                        report_mismatch($sformatf("list_size %0d, expected %0d",
                                                  list_size, oldest.size));
                    if (last !== oldest.last)
                        report_mismatch($sformatf("last %0b, expected %0b", last, oldest.last));
                end
            end
            due_count <= due_words.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the sleep timer list block with a directed sequence (empty ticks,
// zero and maximum delays, duplicate tasks, misses, an unused opcode), a fill
// past capacity followed by a tick that wakes every entry, and a random mix of
// pushes, ticks, removes and unused opcodes, mostly over a small task pool. The command
// side idles and the result side stalls at random; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CAPACITY = 32;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode    = stl_pkg::OP_TICK;
    logic [7:0]  task_id   = 8'd0;
    logic [15:0] delay     = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  woken_task;
    logic [6:0]  list_size;
    logic        last;

    int errors;
    int outstanding;

    int  stall_left = 0;
    int  stall_pick;
    bit  gapless    = 1'b0;
    int  push_words = 0;
    int  tick_words = 0;
    int  drop_words = 0;
    int  noise_words = 0;

    sleep_timer_list_unit #(.CAPACITY(CAPACITY)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .task_id    (task_id),
        .delay      (delay),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .woken_task (woken_task),
        .list_size  (list_size),
        .last       (last)
    );

    sleep_timer_list_checker #(.CAPACITY(CAPACITY)) CHK (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .task_id     (task_id),
        .delay       (delay),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .woken_task  (woken_task),
        .list_size   (list_size),
        .last        (last),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hold the result side in random runs of stall and release
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 50)
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(0, 20);
            end
            else if (stall_pick < 85)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end
            else if (stall_pick < 95)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(3, 14);
            end
            else if (stall_pick < 98)
            begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(19, 59);
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(100, 300);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 15);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_task();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 11));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(0, 3));
        else if (r < 90)
            return 16'($urandom_range(4, 20));
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_word(input stl_pkg::opcode_t op, input logic [7:0] tid,
                             input logic [15:0] dly);
        int gap;
        in_valid <= 1'b1;
        opcode   <= op;
        task_id  <= tid;
        delay    <= dly;
        do @(posedge clk); while (in_stall);
        case (op)
            stl_pkg::OP_PUSH:   push_words++;
            stl_pkg::OP_TICK:   tick_words++;
            stl_pkg::OP_REMOVE: drop_words++;
            default:            noise_words++;
        endcase
        gap = gapless ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int          picked;
        int          mixed;
        logic [7:0]  tid;
        logic [15:0] dly;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(stl_pkg::OP_TICK,   8'd0,   16'd0);
        send_word(stl_pkg::OP_NONE,   8'd255, 16'hFFFF);
        send_word(stl_pkg::OP_PUSH,   8'd0,   16'd0);
        send_word(stl_pkg::OP_PUSH,   8'd255, 16'hFFFF);
        send_word(stl_pkg::OP_PUSH,   8'd7,   16'd1);
        send_word(stl_pkg::OP_PUSH,   8'd7,   16'd2);
        send_word(stl_pkg::OP_PUSH,   8'h55,  16'hAAAA);
        send_word(stl_pkg::OP_TICK,   8'hFF,  16'hFFFF);
        send_word(stl_pkg::OP_PUSH,   8'd9,   16'd3);
        send_word(stl_pkg::OP_PUSH,   8'd9,   16'd0);
        send_word(stl_pkg::OP_REMOVE, 8'd9,   16'hFFFF);
        send_word(stl_pkg::OP_REMOVE, 8'd200, 16'd0);
        send_word(stl_pkg::OP_TICK,   8'd0,   16'd0);
        send_word(stl_pkg::OP_REMOVE, 8'd255, 16'd0);
        send_word(stl_pkg::OP_REMOVE, 8'h55,  16'd0);
        send_word(stl_pkg::OP_REMOVE, 8'h55,  16'd0);
        send_word(stl_pkg::OP_TICK,   8'd0,   16'd0);
        send_word(stl_pkg::OP_PUSH,   8'hAA,  16'h5555);
        send_word(stl_pkg::OP_REMOVE, 8'hAA,  16'd0);
        wait_drained();

        // fill past capacity with back-to-back words, then wake everything at once
        gapless = 1'b1;
        for (int k = 0; k < CAPACITY + 1; k++)
            send_word(stl_pkg::OP_PUSH, 8'(100 + k), 16'd1);
        send_word(stl_pkg::OP_TICK, 8'd0, 16'd0);
        gapless = 1'b0;

        mixed = 0;
        while (mixed < 56)
        begin
            picked = $urandom_range(0, 99);
            tid    = pick_task();
            dly    = pick_delay();
            if ($urandom_range(0, 99) < 3)
                gapless = !gapless;
            if (picked < 40)
            begin
                send_word(stl_pkg::OP_PUSH, tid, dly);
                mixed++;
            end
            else if (picked < 73)
            begin
                send_word(stl_pkg::OP_TICK, tid, dly);
                mixed++;
            end
            else if (picked < 94)
            begin
                send_word(stl_pkg::OP_REMOVE, tid, dly);
                mixed++;
            end
            else
            begin
                send_word(stl_pkg::OP_NONE, 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 99) < 4)
                wait_drained();
        end

        wait_drained();
        repeat (60) @(posedge clk);

        $display("covered %0d pushes, %0d ticks, %0d removes and %0d unused-opcode words",
                 push_words, tick_words, drop_words, noise_words);
        $display("including a fill past capacity and a tick that woke a full list");
        if (errors == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/stl_pkg.sv
rtl/stl_entry_ram.sv
rtl/sleep_timer_list_unit.sv
tb/sleep_timer_list_checker.sv
tb/testbench.sv
